// ===== src/stz_pkg.sv =====
package stz_pkg;

    localparam int ACCEL_W    = 20;
    localparam int INTERVAL_W = 40;
    localparam int RAMP_W     = 32;
    localparam int SPEED_W    = 32;
    localparam int IV_US_W    = 32;
    localparam int SPEED_FRAC = 12;

    // v^2 carries twice the speed fraction; the extra bit is the 2 in 2a
    localparam int SQ_SHIFT = 2 * SPEED_FRAC + 1;

    localparam logic [ACCEL_W-1:0]    US_PER_S    = 20'd1000000;
    localparam logic [IV_US_W-1:0]    NO_ACCEL_US = 32'd2000;
    localparam logic [INTERVAL_W-1:0] IVL_MAX     = {INTERVAL_W{1'b1}};
    localparam logic [SPEED_W-1:0]    SPEED_MAX   = {SPEED_W{1'b1}};
    localparam logic [RAMP_W-1:0]     RAMP_MAX    = {1'b0, {(RAMP_W-1){1'b1}}};
    localparam logic [RAMP_W-1:0]     RAMP_MIN    = {1'b1, {(RAMP_W-1){1'b0}}};

    localparam logic KIND_MOVE = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_IVL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_IVL   = 2'd2;

endpackage

// ===== src/stz_in_if.sv =====
interface stz_in_if #(
    parameter int POSITION_BITS = 32
);
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic signed [POSITION_BITS-1:0] target_position;
    logic signed [POSITION_BITS-1:0] current_position;

    modport source (
        output valid, kind, target_position, current_position,
        input  ready
    );
    modport sink (
        input  valid, kind, target_position, current_position,
        output ready
    );
endinterface

// ===== src/stz_out_if.sv =====
interface stz_out_if;
    logic                           valid;
    logic                           ready;
    logic [stz_pkg::IV_US_W-1:0]    interval_us;
    logic                           running;

    modport source (
        output valid, interval_us, running,
        input  ready
    );
    modport sink (
        input  valid, interval_us, running,
        output ready
    );
endinterface

// ===== src/stz_div.sv =====
module stz_div #(
    parameter int NUM_W = 41,
    parameter int DEN_W = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;

    logic [DEN_W:0]   w_trial;
    logic [DEN_W+1:0] w_diff;
    logic             w_fits;

    // restoring step: bring down the next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_den};
    assign w_fits  = !w_diff[DEN_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== src/stepper_trapezoid_interval.sv =====
// Move transaction: result registered at acceptance, valid in the next cycle.
// Step transaction: the result is computed with one restoring divider, shared in turn for
// stopping distance, ramp delta and speed, one quotient bit per cycle.
// One transaction at a time.
// Synchronous active-low reset clears the ramp state, goal, registers and output valid.
module stepper_trapezoid_interval #(
    parameter int POSITION_BITS = 32,
    parameter int FRAC_BITS     = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [stz_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [stz_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    stz_in_if.sink                            i_in,
    stz_out_if.source                         o_out
);

    localparam int IW    = stz_pkg::INTERVAL_W;
    localparam int NUM_W = (FRAC_BITS + 32 > IW + 1) ? FRAC_BITS + 32 : IW + 1;
    localparam int CMP_W = (NUM_W > POSITION_BITS) ? NUM_W : POSITION_BITS;
    localparam int SQ_W  = 2 * stz_pkg::SPEED_W;
    localparam logic [NUM_W-1:0] SPEED_NUM =
        NUM_W'(stz_pkg::US_PER_S) << (FRAC_BITS + stz_pkg::SPEED_FRAC);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIST  = 4'd1;
    localparam logic [3:0] S_SQ    = 4'd2;
    localparam logic [3:0] S_STEPS = 4'd3;
    localparam logic [3:0] S_DECEL = 4'd4;
    localparam logic [3:0] S_IVL   = 4'd5;
    localparam logic [3:0] S_DELTA = 4'd6;
    localparam logic [3:0] S_CLAMP = 4'd7;
    localparam logic [3:0] S_SPEED = 4'd8;
    localparam logic [3:0] S_RATE  = 4'd9;

    logic [3:0]                      r_state;
    logic [stz_pkg::ACCEL_W-1:0]     r_accel;
    logic [IW-1:0]                   r_first;
    logic [IW-1:0]                   r_min;
    logic [IW-1:0]                   r_ivl;
    logic signed [POSITION_BITS-1:0] r_goal;
    logic signed [POSITION_BITS-1:0] r_cur;
    logic [POSITION_BITS-1:0]        r_adist;
    logic [stz_pkg::RAMP_W-1:0]      r_ramp;
    logic [stz_pkg::SPEED_W-1:0]     r_speed;
    logic [SQ_W-1:0]                 r_sq;
    logic                            r_out_valid;
    logic [stz_pkg::IV_US_W-1:0]     r_out_iv;
    logic                            r_out_run;

    logic                     w_in_ready;
    logic                     w_in_acc;
    logic                     w_out_take;
    logic                     w_out_load;
    logic [POSITION_BITS:0]   w_dist;
    logic [POSITION_BITS:0]   w_adist;
    logic                     w_ramp_pos;
    logic [34:0]              w_den4;
    logic [34:0]              w_den_mag;
    logic                     w_div_start;
    logic [NUM_W-1:0]         w_div_num;
    logic [IW-1:0]            w_div_den;
    logic                     w_div_done;
    logic [NUM_W-1:0]         w_quo;
    logic                     w_steps_big;
    logic                     w_steps_ge;
    logic                     w_sub_ok;
    logic [NUM_W:0]           w_sum;
    logic [stz_pkg::IV_US_W-1:0] w_iv_us;

    assign w_in_ready = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign w_in_acc   = i_in.valid && w_in_ready;
    assign w_out_take = r_out_valid && o_out.ready;

    assign w_dist  = {r_goal[POSITION_BITS-1], r_goal} - {r_cur[POSITION_BITS-1], r_cur};
    assign w_adist = w_dist[POSITION_BITS] ? -w_dist : w_dist;

    // a result is loaded at the end of each path through the sequence
    assign w_out_load = (w_in_acc && (i_in.kind == stz_pkg::KIND_MOVE)) ||
                        ((r_state == S_DIST) && ((w_dist == '0) || (r_accel == '0))) ||
                        ((r_state == S_SPEED) && (r_ivl == '0)) ||
                        ((r_state == S_RATE) && w_div_done);

    assign w_ramp_pos = !r_ramp[stz_pkg::RAMP_W-1] && (r_ramp != '0);

    // 4n+1 with one guard bit, then its magnitude
    assign w_den4    = {r_ramp[stz_pkg::RAMP_W-1], r_ramp, 2'b01};
    assign w_den_mag = w_den4[34] ? -w_den4 : w_den4;

    assign w_steps_big = |w_quo[NUM_W-1:stz_pkg::RAMP_W-1];
    assign w_steps_ge  = CMP_W'(w_quo) >= CMP_W'(r_adist);
    assign w_sub_ok    = NUM_W'(r_ivl) >= w_quo;
    assign w_sum       = (NUM_W+1)'(r_ivl) + (NUM_W+1)'(w_quo);
    assign w_iv_us     = stz_pkg::IV_US_W'(r_ivl >> FRAC_BITS);

    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = SPEED_NUM;
        w_div_den   = r_ivl;
        unique case (r_state)
            S_STEPS: begin
                w_div_start = 1'b1;
                w_div_num   = NUM_W'(r_sq[SQ_W-1:stz_pkg::SQ_SHIFT]);
                w_div_den   = IW'(r_accel);
            end
            S_IVL: begin
                w_div_start = (r_ramp != '0);
                w_div_num   = NUM_W'({r_ivl, 1'b0});
                w_div_den   = IW'(w_den_mag);
            end
            S_SPEED: begin
                w_div_start = (r_ivl != '0);
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    stz_div #(
        .NUM_W (NUM_W),
        .DEN_W (IW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_accel     <= '0;
            r_first     <= '0;
            r_min       <= '0;
            r_goal      <= '0;
            r_ramp      <= '0;
            r_ivl       <= '0;
            r_speed     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    stz_pkg::CFG_ACCEL:     r_accel <= i_cfg_wdata[stz_pkg::ACCEL_W-1:0];
                    stz_pkg::CFG_FIRST_IVL: r_first <= i_cfg_wdata[IW-1:0];
                    stz_pkg::CFG_MIN_IVL:   r_min   <= i_cfg_wdata[IW-1:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_cur <= i_in.current_position;
                        if (i_in.kind == stz_pkg::KIND_MOVE) begin
                            if (r_goal != i_in.target_position) begin
                                r_goal <= i_in.target_position;
                                // restart the ramp only from standstill
                                if (r_speed == '0) begin
                                    r_ramp <= '0;
                                end
                            end
                            r_out_iv    <= '0;
                            r_out_run   <= (r_speed != '0) ||
                                           (i_in.target_position != i_in.current_position);
                        end else begin
                            r_state <= S_DIST;
                        end
                    end
                end
                S_DIST: begin
                    r_adist <= w_adist[POSITION_BITS-1:0];
                    if (w_dist == '0) begin
                        r_speed     <= '0;
                        r_ivl       <= '0;
                        r_ramp      <= '0;
                        r_out_iv    <= '0;
                        r_out_run   <= 1'b0;
                        r_state     <= S_IDLE;
                    end else if (r_accel == '0) begin
                        r_out_iv    <= stz_pkg::NO_ACCEL_US;
                        r_out_run   <= 1'b1;
                        r_state     <= S_IDLE;
                    end else if (w_ramp_pos) begin
                        r_state <= S_SQ;
                    end else begin
                        r_state <= S_IVL;
                    end
                end
                S_SQ: begin
                    r_sq    <= SQ_W'(r_speed) * SQ_W'(r_speed);
                    r_state <= S_STEPS;
                end
                S_STEPS: begin
                    r_state <= S_DECEL;
                end
                S_DECEL: begin
                    if (w_div_done) begin
                        // start braking once the stopping distance covers what is left
                        if (w_steps_ge) begin
                            r_ramp <= w_steps_big ? stz_pkg::RAMP_MIN
                                                  : -w_quo[stz_pkg::RAMP_W-1:0];
                        end
                        r_state <= S_IVL;
                    end
                end
                S_IVL: begin
                    if (r_ramp == '0) begin
                        r_ivl   <= r_first;
                        r_ramp  <= stz_pkg::RAMP_W'(1);
                        r_state <= S_SPEED;
                    end else begin
                        r_state <= S_DELTA;
                    end
                end
                S_DELTA: begin
                    if (w_div_done) begin
                        if (!r_ramp[stz_pkg::RAMP_W-1]) begin
                            r_ivl <= w_sub_ok ? r_ivl - w_quo[IW-1:0] : '0;
                        end else begin
                            r_ivl <= (|w_sum[NUM_W:IW]) ? stz_pkg::IVL_MAX : w_sum[IW-1:0];
                        end
                        r_state <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    if (r_ivl < r_min) begin
                        r_ivl <= r_min;
                    end
                    if (r_ramp != stz_pkg::RAMP_MAX) begin
                        r_ramp <= r_ramp + stz_pkg::RAMP_W'(1);
                    end
                    r_state <= S_SPEED;
                end
                S_SPEED: begin
                    if (r_ivl == '0) begin
                        r_speed     <= stz_pkg::SPEED_MAX;
                        r_out_iv    <= w_iv_us;
                        r_out_run   <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_RATE;
                    end
                end
                S_RATE: begin
                    if (w_div_done) begin
                        r_speed     <= (|w_quo[NUM_W-1:stz_pkg::SPEED_W])
                                       ? stz_pkg::SPEED_MAX
                                       : w_quo[stz_pkg::SPEED_W-1:0];
                        r_out_iv    <= w_iv_us;
                        r_out_run   <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready        = w_in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.interval_us = r_out_iv;
    assign o_out.running     = r_out_run;

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_in.ready)
        else $error("input ready while a step transaction is in progress");

    a_step_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in.kind == stz_pkg::KIND_STEP)) |=> (r_state == S_DIST))
        else $error("accepted step transaction did not start the sequence");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DECEL || r_state == S_DELTA || r_state == S_RATE))
        else $error("divider finished outside a wait state");

    a_clamp_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLAMP) |=> (r_ivl >= $past(r_min)))
        else $error("interval below minimum after clamp");

endmodule

// ===== tb/tb_stepper_trapezoid_interval.sv =====
`timescale 1ns / 1ps

module tb_stepper_trapezoid_interval;

    localparam int          POSITION_BITS = 32;
    localparam int          FRAC_BITS     = 8;
    localparam int unsigned ITEM_TOTAL    = 1325;
    localparam int          SETTLE_CYCLES = 160;
    // allow for the worst step and for idling on both sides several times over
    localparam longint      CYCLE_LIMIT   = 2_000_000;
    localparam int unsigned ACCEL_TOP     = 1_000_000;
    localparam int unsigned IDLE_PCT      = 36;
    localparam int unsigned PRINT_CAP     = 100;

    typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_CHECKED} t_row_op;

    typedef struct packed {
        t_row_op                             op;
        logic [stz_pkg::CFG_IDX_W-1:0]       idx;
        logic [stz_pkg::CFG_DATA_W-1:0]      data;
        logic                                kind;
        logic [POSITION_BITS-1:0]            target;
        logic [POSITION_BITS-1:0]            current;
        logic [stz_pkg::IV_US_W-1:0]         interval_us;
        logic                                running;
    } t_script_row;

    typedef struct packed {
        logic [stz_pkg::IV_US_W-1:0] interval_us;
        logic                        running;
    } t_step_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_wr_en;
    logic [stz_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [stz_pkg::CFG_DATA_W-1:0] i_cfg_wdata;

    stz_in_if #(.POSITION_BITS(POSITION_BITS)) in_if ();
    stz_out_if out_if ();

    stepper_trapezoid_interval #(
        .POSITION_BITS(POSITION_BITS),
        .FRAC_BITS    (FRAC_BITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // ramp state and registers as the block should hold them
    longint                         goal_pos;
    int                             ramp_n;
    longint unsigned                ivl_q;
    logic [stz_pkg::SPEED_W-1:0]    speed_q;
    logic [stz_pkg::ACCEL_W-1:0]    cfg_accel;
    longint unsigned                cfg_c0;
    longint unsigned                cfg_cmin;

    t_step_result          pending_intervals[$];
    t_script_row           script[$];
    int unsigned           mismatches = 0;
    int unsigned           n_sent;
    longint                cycle_count = 0;
    bit                    idle_on = 1'b1;
    logic signed [POSITION_BITS-1:0] pos;

    always #6 i_clk = ~i_clk;

    function automatic void predict_interval(input logic kind,
                                             input logic signed [POSITION_BITS-1:0] tgt,
                                             input logic signed [POSITION_BITS-1:0] cur,
                                             output logic [stz_pkg::IV_US_W-1:0] iv,
                                             output logic run);
        longint          gap;
        longint          den;
        longint unsigned adist, sq, stop_steps, delta, mag, num, q;
        iv = '0;
        if (kind == stz_pkg::KIND_MOVE) begin
            if (goal_pos != longint'(tgt)) begin
                goal_pos = longint'(tgt);
                if (speed_q == 0)
                    ramp_n = 0;
            end
        end else begin
            gap = goal_pos - longint'(cur);
            if (gap == 0) begin
                speed_q = '0;
                ivl_q   = 0;
                ramp_n  = 0;
            end else if (cfg_accel == 0) begin
                iv = stz_pkg::NO_ACCEL_US;
            end else begin
                adist      = (gap < 0) ? -gap : gap;
                sq         = 64'(speed_q) * 64'(speed_q);
                stop_steps = sq / (64'(cfg_accel) << stz_pkg::SQ_SHIFT);
                // start braking once the stopping distance covers what is left
                if (ramp_n > 0 && stop_steps >= adist) begin
                    if (stop_steps >= 64'h8000_0000)
                        ramp_n = int'(stz_pkg::RAMP_MIN);
                    else
                        ramp_n = -int'(stop_steps);
                end
                if (ramp_n == 0) begin
                    ivl_q = cfg_c0;
                end else begin
                    den   = 4 * longint'(ramp_n) + 1;
                    mag   = (den < 0) ? -den : den;
                    delta = (2 * ivl_q) / mag;
                    if (den > 0) begin
                        ivl_q = (ivl_q >= delta) ? ivl_q - delta : 0;
                    end else begin
                        ivl_q = ivl_q + delta;
                        if (ivl_q > stz_pkg::IVL_MAX)
                            ivl_q = stz_pkg::IVL_MAX;
                    end
                    if (ivl_q < cfg_cmin)
                        ivl_q = cfg_cmin;
                end
                if (ramp_n != int'(stz_pkg::RAMP_MAX))
                    ramp_n++;
                num = 64'(stz_pkg::US_PER_S) << (FRAC_BITS + stz_pkg::SPEED_FRAC);
                if (ivl_q == 0) begin
                    speed_q = stz_pkg::SPEED_MAX;
                end else begin
                    q       = num / ivl_q;
                    speed_q = (q > stz_pkg::SPEED_MAX) ? stz_pkg::SPEED_MAX
                                                       : q[stz_pkg::SPEED_W-1:0];
                end
                iv = ivl_q[FRAC_BITS +: stz_pkg::IV_US_W];
            end
        end
        run = (speed_q != 0) || (goal_pos != longint'(cur));
    endfunction

    function automatic logic [stz_pkg::CFG_DATA_W-1:0] rand40();
        return {8'($urandom), 32'($urandom)};
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic add_reg_row(input logic [stz_pkg::CFG_IDX_W-1:0] idx,
                               input logic [stz_pkg::CFG_DATA_W-1:0] data);
        t_script_row r;
        r      = '0;
        r.op   = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        script.push_back(r);
    endtask

    task automatic add_item_row(input logic kind, input logic [POSITION_BITS-1:0] tgt,
                                input logic [POSITION_BITS-1:0] cur);
        t_script_row r;
        r         = '0;
        r.op      = ROW_ITEM;
        r.kind    = kind;
        r.target  = tgt;
        r.current = cur;
        script.push_back(r);
    endtask

    task automatic add_checked_row(input logic kind, input logic [POSITION_BITS-1:0] tgt,
                                   input logic [POSITION_BITS-1:0] cur,
                                   input logic [stz_pkg::IV_US_W-1:0] iv, input logic run);
        t_script_row r;
        r             = '0;
        r.op          = ROW_CHECKED;
        r.kind        = kind;
        r.target      = tgt;
        r.current     = cur;
        r.interval_us = iv;
        r.running     = run;
        script.push_back(r);
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic write_reg(input logic [stz_pkg::CFG_IDX_W-1:0] idx,
                             input logic [stz_pkg::CFG_DATA_W-1:0] data);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = data;
        case (idx)
            stz_pkg::CFG_ACCEL:     cfg_accel = data[stz_pkg::ACCEL_W-1:0];
            stz_pkg::CFG_FIRST_IVL: cfg_c0    = 64'(data);
            stz_pkg::CFG_MIN_IVL:   cfg_cmin  = 64'(data);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_intervals.size() != 0)
            @(negedge i_clk);
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic offer_item(input logic kind, input logic [POSITION_BITS-1:0] tgt,
                              input logic [POSITION_BITS-1:0] cur, input bit typed,
                              input logic [stz_pkg::IV_US_W-1:0] typed_iv,
                              input logic typed_run);
        t_step_result r;
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid            = 1'b1;
        in_if.kind             = kind;
        in_if.target_position  = tgt;
        in_if.current_position = cur;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        predict_interval(kind, tgt, cur, r.interval_us, r.running);
        if (typed) begin
            r.interval_us = typed_iv;
            r.running     = typed_run;
        end
        pending_intervals.push_back(r);
        n_sent++;
        @(negedge i_clk);
        // drop valid so the transaction is not offered twice
        in_if.valid = 1'b0;
    endtask

    task automatic pick_ramp_profile();
        logic [stz_pkg::ACCEL_W-1:0]    accel;
        logic [stz_pkg::CFG_DATA_W-1:0] c0;
        logic [stz_pkg::CFG_DATA_W-1:0] cmin;
        real                            c0_us;
        case ($urandom_range(0, 9))
            0:       accel = '0;
            1:       accel = 20'd1;
            2:       accel = 20'(ACCEL_TOP);
            3:       accel = 20'($urandom_range(0, ACCEL_TOP));
            default: accel = 20'($urandom_range(200, 100_000));
        endcase
        if (accel != 0 && $urandom_range(0, 9) != 0) begin
            // c0 = 0.676 * sqrt(2/a) seconds, as host software would load it
            c0_us = 0.676 * $sqrt(2.0 / real'(accel)) * 1.0e6;
            c0    = 40'(longint'(c0_us * 256.0));
        end else begin
            c0 = rand40();
        end
        case ($urandom_range(0, 9))
            0:       cmin = '0;
            1:       cmin = stz_pkg::IVL_MAX;
            2:       cmin = rand40();
            default: cmin = c0 / $urandom_range(2, 40);
        endcase
        if ($urandom_range(0, 9) < 8)
            write_reg(stz_pkg::CFG_ACCEL, 40'(accel));
        if ($urandom_range(0, 9) < 8)
            write_reg(stz_pkg::CFG_FIRST_IVL, c0);
        if ($urandom_range(0, 9) < 8)
            write_reg(stz_pkg::CFG_MIN_IVL, cmin);
    endtask

    task automatic run_move();
        logic signed [POSITION_BITS-1:0] dest;
        int                              span;
        int unsigned                     step_cap;
        int unsigned                     taken;
        case ($urandom_range(0, 19))
            0:       dest = pos;
            1:       dest = $urandom;
            default: begin
                span = $urandom_range(1, 90);
                dest = $urandom_range(0, 1) ? pos + span : pos - span;
            end
        endcase
        if ($urandom_range(0, 19) == 0)
            wait_drained();
        offer_item(stz_pkg::KIND_MOVE, dest, pos, 1'b0, '0, 1'b0);
        // abandon some moves part way so the next target lands mid-ramp
        step_cap = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 20) : 200;
        taken    = 0;
        while (pos != dest && taken < step_cap) begin
            offer_item(stz_pkg::KIND_STEP, $urandom, pos, 1'b0, '0, 1'b0);
            pos = (dest > pos) ? pos + 1 : pos - 1;
            taken++;
        end
        if (pos == dest)
            offer_item(stz_pkg::KIND_STEP, $urandom, pos, 1'b0, '0, 1'b0);
    endtask

    always @(negedge i_clk)
        out_if.ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge i_clk) begin : check_results
        t_step_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_intervals.size() == 0) begin
                report_mismatch("result with nothing awaited", out_if.interval_us, 0);
            end else begin
                want = pending_intervals.pop_front();
                if (out_if.interval_us !== want.interval_us)
                    report_mismatch("interval_us", out_if.interval_us, want.interval_us);
                if (out_if.running !== want.running)
                    report_mismatch("running", out_if.running, want.running);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        i_rst_n                = 1'b0;
        i_cfg_wr_en            = 1'b0;
        i_cfg_index            = stz_pkg::CFG_ACCEL;
        i_cfg_wdata            = '0;
        in_if.valid            = 1'b0;
        in_if.kind             = stz_pkg::KIND_MOVE;
        in_if.target_position  = '0;
        in_if.current_position = '0;
        out_if.ready           = 1'b0;
        goal_pos               = 0;
        ramp_n                 = 0;
        ivl_q                  = 0;
        speed_q                = '0;
        cfg_accel              = '0;
        cfg_c0                 = 0;
        cfg_cmin               = 0;
        pos                    = '0;
        n_sent                 = 0;

        // straight out of reset: at target, then no acceleration loaded
        add_checked_row(stz_pkg::KIND_STEP, 32'd0, 32'd0, '0, 1'b0);
        add_checked_row(stz_pkg::KIND_MOVE, 32'd100, 32'd0, '0, 1'b1);
        add_checked_row(stz_pkg::KIND_STEP, 32'd0, 32'd0, stz_pkg::NO_ACCEL_US, 1'b1);
        add_checked_row(stz_pkg::KIND_MOVE, 32'h8000_0000, 32'h7FFF_FFFF, '0, 1'b1);
        add_checked_row(stz_pkg::KIND_MOVE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, 1'b0);
        add_checked_row(stz_pkg::KIND_STEP, 32'd0, 32'h8000_0000, stz_pkg::NO_ACCEL_US,
                        1'b1);
        // a short realistic move; the first step reloads c0 unclamped
        add_reg_row(stz_pkg::CFG_ACCEL, 40'd1000);
        add_reg_row(stz_pkg::CFG_FIRST_IVL, 40'd7739289);
        add_reg_row(stz_pkg::CFG_MIN_IVL, 40'd25600);
        add_checked_row(stz_pkg::KIND_MOVE, 32'd6, 32'd0, '0, 1'b1);
        add_checked_row(stz_pkg::KIND_STEP, 32'd0, 32'd0, 32'd30231, 1'b1);
        for (int p = 1; p < 6; p++)
            add_item_row(stz_pkg::KIND_STEP, 32'd0, p);
        add_checked_row(stz_pkg::KIND_STEP, 32'd0, 32'd6, '0, 1'b0);
        // widest intervals: speed truncates to zero
        add_reg_row(stz_pkg::CFG_FIRST_IVL, stz_pkg::IVL_MAX);
        add_reg_row(stz_pkg::CFG_MIN_IVL, stz_pkg::IVL_MAX);
        add_checked_row(stz_pkg::KIND_MOVE, 32'hFFFF_FFFD, 32'd6, '0, 1'b1);
        add_checked_row(stz_pkg::KIND_STEP, 32'd0, 32'd6, 32'hFFFF_FFFF, 1'b1);
        add_item_row(stz_pkg::KIND_STEP, 32'd0, 32'd5);
        // zero interval saturates speed, then stop distance saturates the index
        add_reg_row(stz_pkg::CFG_ACCEL, 40'd1);
        add_reg_row(stz_pkg::CFG_FIRST_IVL, 40'd0);
        add_reg_row(stz_pkg::CFG_MIN_IVL, 40'd0);
        add_checked_row(stz_pkg::KIND_MOVE, 32'd9, 32'd0, '0, 1'b1);
        add_checked_row(stz_pkg::KIND_STEP, 32'd0, 32'd0, '0, 1'b1);
        add_item_row(stz_pkg::KIND_STEP, 32'd0, 32'd1);
        add_item_row(stz_pkg::KIND_STEP, 32'd0, 32'd2);
        add_item_row(stz_pkg::KIND_MOVE, 32'd50, 32'd2);
        add_reg_row(stz_pkg::CFG_ACCEL, 40'd0);
        add_checked_row(stz_pkg::KIND_STEP, 32'd0, 32'd3, stz_pkg::NO_ACCEL_US, 1'b1);
        add_reg_row(stz_pkg::CFG_ACCEL, 40'(ACCEL_TOP));
        add_reg_row(stz_pkg::CFG_FIRST_IVL, 40'd244730);
        add_reg_row(stz_pkg::CFG_MIN_IVL, 40'd2560);
        add_item_row(stz_pkg::KIND_STEP, 32'd0, 32'd4);
        add_item_row(stz_pkg::KIND_STEP, 32'd0, 32'd9);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (script[i]) begin
            if (script[i].op == ROW_CFG) begin
                wait_drained();
                write_reg(script[i].idx, script[i].data);
            end else begin
                offer_item(script[i].kind, script[i].target, script[i].current,
                           script[i].op == ROW_CHECKED, script[i].interval_us,
                           script[i].running);
            end
        end
        pos = 32'd9;

        while (n_sent < ITEM_TOTAL) begin
            // registers change only with nothing in flight
            wait_drained();
            idle_on = !(n_sent >= 500 && n_sent < 800);
            pick_ramp_profile();
            repeat ($urandom_range(1, 4)) begin
                if (n_sent < ITEM_TOTAL) begin
                    if ($urandom_range(0, 9) == 0) begin
                        repeat ($urandom_range(1, 4))
                            offer_item(1'($urandom), $urandom, $urandom, 1'b0, '0, 1'b0);
                    end else begin
                        run_move();
                    end
                end
            end
        end
        in_if.valid = 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_intervals.size() != 0)
            report_mismatch("results never delivered", 0, pending_intervals.size());
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
